>>> rtl/tcstg_pkg.sv
// ----------------------------------------------------------------------------
// tcstg_pkg
// Shared widths, codes, types and helpers for the two channel tone generator.
// ----------------------------------------------------------------------------
package tcstg_pkg;

    // field and state widths
    localparam int REQ_W     = 2;
    localparam int FREQ_W    = 15;
    localparam int CNT_W     = 26;
    localparam int EVT_W     = 32;
    localparam int CLK_W     = 27;
    localparam int RATE_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = CLK_W;

    // shared divider operand widths
    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 17;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    localparam int NUM_CHANNELS = 2;
    localparam int QUEUE_DEPTH  = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_START = 2'd2;
    localparam logic [REQ_W-1:0] REQ_STOP  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DUAL_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd2;

    // reset values
    localparam logic [CLK_W-1:0]  CLOCK_HZ_RESET    = 27'd72000000;
    localparam logic [RATE_W-1:0] SAMPLE_RATE_RESET = 17'd44100;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // one queued request
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic              channel;
        logic [FREQ_W-1:0] tone_hz;
    } item_t;

    // match recompute request after a dual mode register write
    typedef struct packed {
        logic              req;
        logic [CLK_W-1:0]  num;
        logic [RATE_W-1:0] den;
    } cfg_recalc_t;

    // divider start request and response
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

    // quotient minus one, clamped at zero, saturated to the counter width
    function automatic logic [CNT_W-1:0] match_from_quotient(
        input logic [DIV_NUM_W-1:0] q
    );
        logic [DIV_NUM_W-1:0] qm1;
        qm1 = q - DIV_NUM_W'(1);
        if (q == '0)
            return '0;
        else if (qm1 > DIV_NUM_W'(CNT_MAX))
            return CNT_MAX;
        else
            return qm1[CNT_W-1:0];
    endfunction

endpackage

>>> rtl/tcstg_div.sv
// ----------------------------------------------------------------------------
// tcstg_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcstg_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tcstg_pkg::div_req_t req,
    output tcstg_pkg::div_rsp_t rsp
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [tcstg_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [tcstg_pkg::DIV_NUM_W-1:0]     quo_reg;
    logic [tcstg_pkg::DIV_DEN_W-1:0]     rem_reg;
    logic [tcstg_pkg::DIV_DEN_W-1:0]     den_reg;

    logic [tcstg_pkg::DIV_DEN_W:0]       rem_sh;
    logic [tcstg_pkg::DIV_DEN_W+1:0]     diff;

    // trial subtract of the shifted remainder
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[tcstg_pkg::DIV_NUM_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, den_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == {tcstg_pkg::DIV_CNT_W{1'b1}})
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            if (!diff[tcstg_pkg::DIV_DEN_W+1])
            begin
                rem_reg <= diff[tcstg_pkg::DIV_DEN_W-1:0];
                quo_reg <= {quo_reg[tcstg_pkg::DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[tcstg_pkg::DIV_DEN_W-1:0];
                quo_reg <= {quo_reg[tcstg_pkg::DIV_NUM_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

>>> rtl/tcstg_front.sv
// ----------------------------------------------------------------------------
// tcstg_front
// Input side: takes request beats and queues them for the back end.
// ----------------------------------------------------------------------------
module tcstg_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [tcstg_pkg::REQ_W-1:0]        req_type,
    input  logic                               channel,
    input  logic [tcstg_pkg::FREQ_W-1:0]       tone_hz,
    output logic                               item_valid,
    output tcstg_pkg::item_t                   item,
    input  logic                               pop
);

    localparam int PTR_W = $clog2(tcstg_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tcstg_pkg::QUEUE_DEPTH + 1);

    tcstg_pkg::item_t   entry_reg [tcstg_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    tcstg_pkg::item_t   in_item;
    logic               push;

    // sort the beat into a queue entry; only set frequency carries a tone
    always_comb
    begin
        in_item.req_type = req_type;
        in_item.channel  = channel;
        in_item.tone_hz  = (req_type == tcstg_pkg::REQ_SET) ? tone_hz : '0;
    end

    assign in_stall   = (count_reg == CNT_W'(tcstg_pkg::QUEUE_DEPTH));
    assign push       = in_valid && !in_stall;
    assign item_valid = (count_reg != '0);
    assign item       = entry_reg[rd_ptr_reg];

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_item;
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(tcstg_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

>>> rtl/tcstg_back.sv
// ----------------------------------------------------------------------------
// tcstg_back
// Back end: runs queued requests against the timer and tone state.
// ----------------------------------------------------------------------------
module tcstg_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               dual_mode,
    input  logic [tcstg_pkg::CLK_W-1:0]        clock_hz,
    input  logic [tcstg_pkg::RATE_W-1:0]       sample_rate_hz,
    input  tcstg_pkg::cfg_recalc_t             recalc,
    input  logic                               item_valid,
    input  tcstg_pkg::item_t                   item,
    output logic                               pop,
    output tcstg_pkg::div_req_t                div_req,
    input  tcstg_pkg::div_rsp_t                div_rsp,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               buzzer_level,
    output logic                               running
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CFG   = 3'd1;
    localparam logic [2:0] S_FREQ  = 3'd2;
    localparam logic [2:0] S_HALF  = 3'd3;
    localparam logic [2:0] S_PHASE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam int FW = tcstg_pkg::FREQ_W;
    localparam int NW = tcstg_pkg::DIV_NUM_W;
    localparam int DW = tcstg_pkg::DIV_DEN_W;

    logic [2:0]                       state_reg, state_next;
    logic [FW-1:0]                    freq_reg [tcstg_pkg::NUM_CHANNELS];
    logic [FW-1:0]                    freq_next [tcstg_pkg::NUM_CHANNELS];
    logic [FW-1:0]                    last_freq_reg, last_freq_next;
    logic [tcstg_pkg::CNT_W-1:0]      match_reg, match_next;
    logic [tcstg_pkg::CNT_W-1:0]      timer_reg, timer_next;
    logic [tcstg_pkg::EVT_W-1:0]      event_reg, event_next;
    logic                             run_reg, run_next;
    logic                             level_reg, level_next;
    logic                             pend_reg, pend_next;
    logic [tcstg_pkg::CLK_W-1:0]      snap_num_reg, snap_num_next;
    logic [tcstg_pkg::RATE_W-1:0]     snap_den_reg, snap_den_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             out_level_reg, out_level_next;
    logic                             out_run_reg, out_run_next;

    logic                             out_free;
    logic                             push;
    logic [tcstg_pkg::EVT_W-1:0]      event_inc;
    logic [FW-1:0]                    evt_freq;
    logic [tcstg_pkg::RATE_W:0]       half_num;
    logic [DW-1:0]                    half_val;

    assign out_free  = !out_valid_reg || !out_stall;
    assign event_inc = event_reg + 1'b1;
    assign evt_freq  = freq_reg[event_inc[0]];
    assign half_num  = {1'b0, sample_rate_hz} + (tcstg_pkg::RATE_W + 1)'(evt_freq);
    assign half_val  = (div_rsp.quo[DW-1:0] == '0) ? DW'(1) : div_rsp.quo[DW-1:0];

    // request sequencing
    always_comb
    begin
        state_next     = state_reg;
        freq_next      = freq_reg;
        last_freq_next = last_freq_reg;
        match_next     = match_reg;
        timer_next     = timer_reg;
        event_next     = event_reg;
        run_next       = run_reg;
        level_next     = level_reg;
        pend_next      = pend_reg;
        snap_num_next  = snap_num_reg;
        snap_den_next  = snap_den_reg;
        out_valid_next = out_valid_reg;
        out_level_next = out_level_reg;
        out_run_next   = out_run_reg;
        pop            = 1'b0;
        push           = 1'b0;
        div_req.start  = 1'b0;
        div_req.num    = '0;
        div_req.den    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pend_reg)
                begin
                    pend_next = 1'b0;
                    if (snap_den_reg == '0)
                        match_next = tcstg_pkg::CNT_MAX;
                    else
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = NW'(snap_num_reg);
                        div_req.den   = DW'(snap_den_reg);
                        state_next    = S_CFG;
                    end
                end
                else if (item_valid && out_free)
                begin
                    pop = 1'b1;
                    case (item.req_type)
                        tcstg_pkg::REQ_TICK:
                        begin
                            push = 1'b1;
                            if (run_reg)
                            begin
                                if (timer_reg == match_reg)
                                begin
                                    timer_next = '0;
                                    if (dual_mode)
                                    begin
                                        event_next = event_inc;
                                        if (evt_freq == '0)
                                            level_next = 1'b0;
                                        else
                                        begin
                                            // half period of the selected channel
                                            push          = 1'b0;
                                            div_req.start = 1'b1;
                                            div_req.num   = NW'(half_num);
                                            div_req.den   = DW'({evt_freq, 1'b0});
                                            state_next    = S_HALF;
                                        end
                                    end
                                    else if (freq_reg[0] != '0)
                                        level_next = !level_reg;
                                    else
                                        level_next = 1'b0;
                                end
                                else
                                    timer_next = timer_reg + 1'b1;
                            end
                        end
                        tcstg_pkg::REQ_SET:
                        begin
                            push = 1'b1;
                            freq_next[item.channel] = item.tone_hz;
                            if (!dual_mode && !item.channel && item.tone_hz != last_freq_reg
                                && item.tone_hz != '0)
                            begin
                                push           = 1'b0;
                                last_freq_next = item.tone_hz;
                                if (run_reg)
                                    timer_next = '0;
                                div_req.start = 1'b1;
                                div_req.num   = NW'(clock_hz);
                                div_req.den   = DW'({item.tone_hz, 1'b0});
                                state_next    = S_FREQ;
                            end
                        end
                        tcstg_pkg::REQ_START:
                        begin
                            push       = 1'b1;
                            run_next   = 1'b1;
                            timer_next = '0;
                        end
                        default:
                        begin
                            push       = 1'b1;
                            run_next   = 1'b0;
                            level_next = 1'b0;
                        end
                    endcase
                end
            end
            S_CFG:
            begin
                if (div_rsp.done)
                begin
                    match_next = tcstg_pkg::match_from_quotient(div_rsp.quo);
                    state_next = S_IDLE;
                end
            end
            S_FREQ:
            begin
                if (div_rsp.done)
                begin
                    match_next = tcstg_pkg::match_from_quotient(div_rsp.quo);
                    state_next = S_DONE;
                end
            end
            S_HALF:
            begin
                // phase of the event count within the channel period
                if (div_rsp.done)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = event_reg;
                    div_req.den   = half_val;
                    state_next    = S_PHASE;
                end
            end
            S_PHASE:
            begin
                if (div_rsp.done)
                begin
                    level_next = div_rsp.quo[0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a dual mode register write restarts the match recompute
        if (recalc.req)
        begin
            pend_next     = 1'b1;
            snap_num_next = recalc.num;
            snap_den_next = recalc.den;
            if (state_reg == S_IDLE || state_reg == S_CFG)
                state_next = S_IDLE;
        end

        // result register
        if (push)
        begin
            out_valid_next = 1'b1;
            out_level_next = level_next;
            out_run_next   = run_next;
        end
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    // control and tone state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            freq_reg[0]   <= '0;
            freq_reg[1]   <= '0;
            last_freq_reg <= '0;
            match_reg     <= '0;
            timer_reg     <= '0;
            event_reg     <= '0;
            run_reg       <= 1'b0;
            level_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            freq_reg      <= freq_next;
            last_freq_reg <= last_freq_next;
            match_reg     <= match_next;
            timer_reg     <= timer_next;
            event_reg     <= event_next;
            run_reg       <= run_next;
            level_reg     <= level_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        snap_num_reg  <= snap_num_next;
        snap_den_reg  <= snap_den_next;
        out_level_reg <= out_level_next;
        out_run_reg   <= out_run_next;
    end

    assign out_valid    = out_valid_reg;
    assign buzzer_level = out_level_reg;
    assign running      = out_run_reg;

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == S_IDLE && !pend_reg))
        else $error("request taken while busy");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!out_valid_reg || !out_stall))
        else $error("result written over an untaken beat");
`endif

endmodule

>>> rtl/two_channel_square_tone_generator.sv
// ----------------------------------------------------------------------------
// two_channel_square_tone_generator
// Buzzer tone generator: single toggling tone or two alternating channels.
//
//   port group   direction  handshake           payload
//   request      in         in_valid/in_stall   req_type, channel, tone_hz
//   result       out        out_valid/out_stall buzzer_level, running
//   config       in         cfg_we              cfg_index, cfg_data
//
// A beat taken into an empty queue is offered to the back end in the next cycle.
// Ticks, start, stop and set frequency without a match change finish straight from idle.
// A channel 0 frequency change in single mode runs one division (32-step divider).
// A dual mode timer event on an unmuted channel runs two divisions in turn.
// A dual mode register write recomputes the match; queued beats wait until it is done.
// rst_n clears all control state asynchronously; a two-entry queue decouples stalls.
// ----------------------------------------------------------------------------
module two_channel_square_tone_generator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tcstg_pkg::REQ_W-1:0]       req_type,
    input  logic                              channel,
    input  logic [tcstg_pkg::FREQ_W-1:0]      tone_hz,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              buzzer_level,
    output logic                              running,
    input  logic                              cfg_we,
    input  logic [tcstg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcstg_pkg::CFG_W-1:0]       cfg_data
);

    logic                                 dual_mode_reg, dual_mode_next;
    logic [tcstg_pkg::CLK_W-1:0]          clock_hz_reg, clock_hz_next;
    logic [tcstg_pkg::RATE_W-1:0]         rate_reg, rate_next;
    logic                                 cfg_hit;
    tcstg_pkg::cfg_recalc_t               recalc;
    tcstg_pkg::item_t                     item;
    logic                                 item_valid;
    logic                                 pop;
    tcstg_pkg::div_req_t                  div_req;
    tcstg_pkg::div_rsp_t                  div_rsp;

    // register writes
    always_comb
    begin
        dual_mode_next = dual_mode_reg;
        clock_hz_next  = clock_hz_reg;
        rate_next      = rate_reg;
        cfg_hit        = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                tcstg_pkg::CFG_DUAL_MODE:
                begin
                    dual_mode_next = cfg_data[0];
                    cfg_hit        = 1'b1;
                end
                tcstg_pkg::CFG_CLOCK_HZ:
                begin
                    clock_hz_next = cfg_data[tcstg_pkg::CLK_W-1:0];
                    cfg_hit       = 1'b1;
                end
                tcstg_pkg::CFG_SAMPLE_RATE:
                begin
                    rate_next = cfg_data[tcstg_pkg::RATE_W-1:0];
                    cfg_hit   = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
        recalc.req = cfg_hit && dual_mode_next;
        recalc.num = clock_hz_next;
        recalc.den = rate_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dual_mode_reg <= 1'b0;
            clock_hz_reg  <= tcstg_pkg::CLOCK_HZ_RESET;
            rate_reg      <= tcstg_pkg::SAMPLE_RATE_RESET;
        end
        else
        begin
            dual_mode_reg <= dual_mode_next;
            clock_hz_reg  <= clock_hz_next;
            rate_reg      <= rate_next;
        end
    end

    // request queue
    tcstg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .channel    (channel),
        .tone_hz    (tone_hz),
        .item_valid (item_valid),
        .item       (item),
        .pop        (pop)
    );

    // shared divider
    tcstg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // tone engine
    tcstg_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .dual_mode      (dual_mode_reg),
        .clock_hz       (clock_hz_reg),
        .sample_rate_hz (rate_reg),
        .recalc         (recalc),
        .item_valid     (item_valid),
        .item           (item),
        .pop            (pop),
        .div_req        (div_req),
        .div_rsp        (div_rsp),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .buzzer_level   (buzzer_level),
        .running        (running)
    );

endmodule

>>> verif/tcstg_tone_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcstg_tone_checker
// Watches the request, result and register ports of the tone generator. It
// keeps its own copy of the timer, channel and pin state, predicts the pin
// level and run flag for every accepted request beat, and compares each
// result beat in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tcstg_tone_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [tcstg_pkg::REQ_W-1:0]     req_type,
    input  logic                            channel,
    input  logic [tcstg_pkg::FREQ_W-1:0]    tone_hz,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic                            buzzer_level,
    input  logic                            running,
    input  logic                            cfg_we,
    input  logic [tcstg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcstg_pkg::CFG_W-1:0]     cfg_data,
    output int unsigned                     mismatches,
    output int unsigned                     owed
);

    // predicted pin state after one request beat
    typedef struct packed {
        logic level;
        logic run;
    } pin_state_t;

    // shadow registers
    logic                         dual_sh;
    logic [tcstg_pkg::CLK_W-1:0]  timer_hz_sh;
    logic [tcstg_pkg::RATE_W-1:0] rate_sh;

    // shadow tone state
    logic [tcstg_pkg::FREQ_W-1:0] chan_hz [tcstg_pkg::NUM_CHANNELS];
    logic [tcstg_pkg::FREQ_W-1:0] applied_hz;
    logic [tcstg_pkg::CNT_W-1:0]  match_sh;
    logic [tcstg_pkg::CNT_W-1:0]  count_sh;
    logic [tcstg_pkg::EVT_W-1:0]  events_sh;
    logic                         run_sh;
    logic                         level_sh;

    pin_state_t  pin_q [$];
    pin_state_t  oldest;
    int unsigned fail_tally;
    logic        reg_hit;

    assign mismatches = fail_tally;

    // timer period from a division: quotient minus one, clamped and saturated
    function automatic logic [tcstg_pkg::CNT_W-1:0] period_ticks(
        input logic [31:0] num,
        input logic [31:0] den
    );
        logic [31:0] q;
        if (den == 32'd0)
            return tcstg_pkg::CNT_MAX;
        q = num / den;
        if (q == 32'd0)
            return '0;
        q = q - 32'd1;
        if (q > 32'(tcstg_pkg::CNT_MAX))
            return tcstg_pkg::CNT_MAX;
        return q[tcstg_pkg::CNT_W-1:0];
    endfunction

    // one timer match: toggle in single mode, alternate channels in dual mode
    task automatic fire_match();
        logic [tcstg_pkg::FREQ_W-1:0] f;
        logic [31:0]                  half;
        logic [31:0]                  phase;
        if (dual_sh)
        begin
            events_sh = events_sh + 32'd1;
            f = chan_hz[events_sh[0]];
            level_sh = 1'b0;
            if (f != '0)
            begin
                half = (32'(rate_sh) + 32'(f)) / (32'(f) * 32'd2);
                if (half == 32'd0)
                    half = 32'd1;
                phase = events_sh / half;
                level_sh = phase[0];
            end
        end
        else if (chan_hz[0] != '0)
            level_sh = ~level_sh;
        else
            level_sh = 1'b0;
    endtask

    // advance the tone state by one request beat
    task automatic apply_request(
        input logic [tcstg_pkg::REQ_W-1:0]  req,
        input logic                         ch,
        input logic [tcstg_pkg::FREQ_W-1:0] hz
    );
        case (req)
            tcstg_pkg::REQ_TICK:
            begin
                if (run_sh)
                begin
                    if (count_sh == match_sh)
                    begin
                        count_sh = '0;
                        fire_match();
                    end
                    else
                        count_sh = count_sh + 1'b1;
                end
            end
            tcstg_pkg::REQ_SET:
            begin
                chan_hz[ch] = hz;
                if (!dual_sh && ch == 1'b0 && hz != applied_hz && hz != '0)
                begin
                    applied_hz = hz;
                    match_sh = period_ticks(32'(timer_hz_sh), 32'(hz) * 32'd2);
                    if (run_sh)
                        count_sh = '0;
                end
            end
            tcstg_pkg::REQ_START:
            begin
                run_sh = 1'b1;
                count_sh = '0;
            end
            tcstg_pkg::REQ_STOP:
            begin
                run_sh = 1'b0;
                level_sh = 1'b0;
            end
            default:
            begin
                run_sh = run_sh;
            end
        endcase
    endtask

    task automatic report(input string field, input logic want, input logic got);
        fail_tally = fail_tally + 1;
        $display("%0t: %s expected %0b actual %0b", $time, field, want, got);
    endtask

    // predict on request beats, compare on result beats, track register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dual_sh     = 1'b0;
            timer_hz_sh = tcstg_pkg::CLOCK_HZ_RESET;
            rate_sh     = tcstg_pkg::SAMPLE_RATE_RESET;
            for (int i = 0; i < tcstg_pkg::NUM_CHANNELS; i++)
                chan_hz[i] = '0;
            applied_hz  = '0;
            match_sh    = '0;
            count_sh    = '0;
            events_sh   = '0;
            run_sh      = 1'b0;
            level_sh    = 1'b0;
            pin_q.delete();
            fail_tally  = 0;
            owed       <= 0;
        end
        else
        begin
            // result beat against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (pin_q.size() == 0)
                begin
                    fail_tally = fail_tally + 1;
                    $display("%0t: result beat with nothing expected, level %0b running %0b",
                             $time, buzzer_level, running);
                end
                else
                begin
                    oldest = pin_q.pop_front();
                    if (buzzer_level !== oldest.level)
                        report("buzzer_level", oldest.level, buzzer_level);
                    if (running !== oldest.run)
                        report("running", oldest.run, running);
                end
            end

            // register write; a dual mode write recomputes the sample period
            if (cfg_we)
            begin
                reg_hit = 1'b1;
                case (cfg_index)
                    tcstg_pkg::CFG_DUAL_MODE:   dual_sh = cfg_data[0];
                    tcstg_pkg::CFG_CLOCK_HZ:    timer_hz_sh = cfg_data[tcstg_pkg::CLK_W-1:0];
                    tcstg_pkg::CFG_SAMPLE_RATE: rate_sh = cfg_data[tcstg_pkg::RATE_W-1:0];
                    default:                    reg_hit = 1'b0;
                endcase
                if (reg_hit && dual_sh)
                    match_sh = period_ticks(32'(timer_hz_sh), 32'(rate_sh));
            end

            // request beat
            if (in_valid && !in_stall)
            begin
                apply_request(req_type, channel, tone_hz);
                pin_q.push_back('{level: level_sh, run: run_sh});
            end

            owed <= pin_q.size();
        end
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the two channel tone generator with directed and random requests
// across single and dual mode register settings, with random idle and stall
// cycles on both channels, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int          RECALC_WAIT = 40;
    localparam int          DRAIN_TAIL  = 100;

    // register index with no register behind it
    localparam logic [tcstg_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    logic [tcstg_pkg::REQ_W-1:0]     req_type  = tcstg_pkg::REQ_TICK;
    logic                            channel   = 1'b0;
    logic [tcstg_pkg::FREQ_W-1:0]    tone_hz   = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic                            buzzer_level;
    logic                            running;
    logic                            cfg_we    = 1'b0;
    logic [tcstg_pkg::CFG_IDX_W-1:0] cfg_index = tcstg_pkg::CFG_DUAL_MODE;
    logic [tcstg_pkg::CFG_W-1:0]     cfg_data  = '0;

    logic                            steady    = 1'b0;
    int unsigned                     mismatches;
    int unsigned                     owed;
    int unsigned                     quiet     = 0;

    two_channel_square_tone_generator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .channel      (channel),
        .tone_hz      (tone_hz),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .buzzer_level (buzzer_level),
        .running      (running),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    tcstg_tone_checker tone_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .channel      (channel),
        .tone_hz      (tone_hz),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .buzzer_level (buzzer_level),
        .running      (running),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .owed         (owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stalls at random outside the steady stretch
    always @(posedge clk)
    begin
        out_stall <= !steady && ($urandom_range(0, 99) < 11);
    end

    // watchdog: cycles with work owed but no beat moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (owed == 0 && !in_valid))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("two_channel_square_tone_generator verification failed");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    // one request beat, with an occasional idle gap in front
    task automatic send(
        input logic [tcstg_pkg::REQ_W-1:0]  req,
        input logic                         ch,
        input logic [tcstg_pkg::FREQ_W-1:0] hz
    );
        int gap;
        if (!steady && $urandom_range(0, 99) < 11)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        channel  <= ch;
        tone_hz  <= hz;
        do @(posedge clk); while (in_stall);
    endtask

    // hold the sender until every predicted result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (owed != 0)
            @(posedge clk);
    endtask

    // register write, then room for the period recompute
    task automatic write_reg(
        input logic [tcstg_pkg::CFG_IDX_W-1:0] idx,
        input logic [tcstg_pkg::CFG_W-1:0]     data
    );
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        repeat (RECALC_WAIT) @(posedge clk);
    endtask

    // mostly ticks so the timer reaches its matches, with tone changes mixed in
    task automatic random_request();
        int                           pick;
        int                           shape;
        logic                         ch;
        logic [tcstg_pkg::FREQ_W-1:0] hz;
        pick  = $urandom_range(0, 99);
        shape = $urandom_range(0, 9);
        ch    = 1'($urandom_range(0, 1));
        if (shape < 7)
            hz = tcstg_pkg::FREQ_W'($urandom_range(8000, 32767));
        else if (shape < 8)
            hz = '0;
        else
            hz = tcstg_pkg::FREQ_W'($urandom_range(0, 32767));
        if (pick < 86)
            send(tcstg_pkg::REQ_TICK, ch, hz);
        else if (pick < 94)
            send(tcstg_pkg::REQ_SET, ch, hz);
        else if (pick < 98)
            send(tcstg_pkg::REQ_START, ch, hz);
        else
            send(tcstg_pkg::REQ_STOP, ch, hz);
    endtask

    task automatic run_phase(
        input logic                         dual,
        input logic [tcstg_pkg::CLK_W-1:0]  timer_hz,
        input logic [tcstg_pkg::RATE_W-1:0] rate,
        input int                           beats,
        input logic                         calm
    );
        wait_drained();
        write_reg(tcstg_pkg::CFG_CLOCK_HZ, tcstg_pkg::CFG_W'(timer_hz));
        write_reg(tcstg_pkg::CFG_SAMPLE_RATE, tcstg_pkg::CFG_W'(rate));
        write_reg(tcstg_pkg::CFG_DUAL_MODE, tcstg_pkg::CFG_W'(dual));
        steady <= calm;
        repeat (beats) random_request();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, single mode
        send(tcstg_pkg::REQ_TICK,  1'b0, 15'd0);        // tick while stopped
        send(tcstg_pkg::REQ_SET,   1'b1, 15'h7FFF);     // channel 1 only stores
        send(tcstg_pkg::REQ_SET,   1'b0, 15'd20000);
        send(tcstg_pkg::REQ_SET,   1'b0, 15'd20000);    // same tone, no new period
        send(tcstg_pkg::REQ_START, 1'b0, 15'd0);
        send(tcstg_pkg::REQ_TICK,  1'b1, 15'h7FFF);
        send(tcstg_pkg::REQ_TICK,  1'b0, 15'h2AAA);
        send(tcstg_pkg::REQ_SET,   1'b0, 15'd1);        // new period while running restarts timer
        send(tcstg_pkg::REQ_TICK,  1'b0, 15'h5555);
        send(tcstg_pkg::REQ_SET,   1'b0, 15'd0);        // mute keeps the period
        send(tcstg_pkg::REQ_STOP,  1'b0, 15'd0);
        send(tcstg_pkg::REQ_TICK,  1'b1, 15'd0);
        send(tcstg_pkg::REQ_START, 1'b1, 15'h7FFF);
        send(tcstg_pkg::REQ_START, 1'b0, 15'd0);
        send(tcstg_pkg::REQ_SET,   1'b1, 15'd0);
        send(tcstg_pkg::REQ_SET,   1'b0, 15'd16384);
        send(tcstg_pkg::REQ_TICK,  1'b0, 15'd0);
        send(tcstg_pkg::REQ_STOP,  1'b1, 15'h7FFF);
        send(tcstg_pkg::REQ_STOP,  1'b0, 15'd0);

        // write to an index with no register
        wait_drained();
        write_reg(CFG_SPARE, tcstg_pkg::CFG_W'($urandom));

        // short single mode periods
        run_phase(1'b0, 27'd1000000, 17'd96000, 140, 1'b0);
        // dual mode, short sample period, no idling on either side
        run_phase(1'b1, 27'd1000000, 17'd96000, 150, 1'b1);
        // dual mode with a rate low enough for a zero half period
        run_phase(1'b1, 27'd200000, 17'd10000, 100, 1'b0);
        // single mode with periods clamped at zero
        run_phase(1'b0, 27'd50000, 17'd40000, 80, 1'b0);
        // dual mode with zero rate, saturated period
        run_phase(1'b1, 27'd100000000, 17'd0, 10, 1'b0);
        // largest clock over a unit rate saturates too
        run_phase(1'b1, 27'h7FFFFFF, 17'd1, 8, 1'b0);
        // back to single mode, dual period kept until channel 0 changes
        run_phase(1'b0, 27'd1000000, 17'd44100, 60, 1'b0);

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);

        if (mismatches == 0 && owed == 0)
            $display("two_channel_square_tone_generator verification clean");
        else
            $display("two_channel_square_tone_generator verification failed");
        $finish;
    end

endmodule

>>> two_channel_square_tone_generator.f
rtl/tcstg_pkg.sv
rtl/tcstg_div.sv
rtl/tcstg_front.sv
rtl/tcstg_back.sv
rtl/two_channel_square_tone_generator.sv
verif/tcstg_tone_checker.sv
verif/tb.sv
